// File: hw/rtl/lcpc_pkg.sv
package lcpc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CrcW   = 16;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CountW = 17;

  localparam logic [CrcW-1:0]   CrcInit   = 16'hFFFF;
  localparam logic [CrcW-1:0]   CrcPoly   = 16'h1021;
  localparam logic [LenW-1:0]   MaxLenRst = 16'd4096;
  localparam logic [CountW-1:0] MinLen    = 17'd4;
  localparam logic [CountW-1:0] CountMax  = 17'h1FFFF;

  // Verdict codes, first failing check wins
  typedef enum logic [2:0] {
    ST_VALID     = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_LEN_MISM  = 3'd3,
    ST_CRC_MISM  = 3'd4
  } status_e;

  // Registered input byte handed to the checker core
  typedef struct packed {
    logic             vld;
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } lcpc_item_t;

  // CRC-16/CCITT-FALSE update by one byte, MSB first
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/lcpc_byte_if.sv
interface lcpc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/lcpc_verdict_if.sv
interface lcpc_verdict_if;
  logic        valid;
  logic        ready;
  logic        packet_ok;
  logic [2:0]  status;
  logic [15:0] computed_crc;

  modport source (output valid, output packet_ok, output status, output computed_crc,
                  input ready);
  modport sink (input valid, input packet_ok, input status, input computed_crc,
                output ready);
endinterface

// File: hw/rtl/length_crc_packet_checker.sv
// Pipeline: a byte is registered in the input stage on transfer and its verdict, if it is
// the final byte, is registered in the core's result register when that byte moves on.
// Throughput: one byte per cycle unless stalled as below; the eight-bit CRC update is combinational.
// A final byte stalls only while the previous verdict is still waiting to be taken.
// Reset (rst_ni low, asynchronous): packet state cleared, max_length back to 4096.
module length_crc_packet_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lcpc_byte_if.sink                   pkt_i,
  lcpc_verdict_if.source              vrd_o,
  input  logic                        cfg_wr_en_i,
  input  logic [lcpc_pkg::LenW-1:0]   cfg_wr_data_i
);
  import lcpc_pkg::*;

  logic [LenW-1:0] max_len_q;
  lcpc_item_t      item;
  logic            advance;

  // Hold the max_length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenRst;
    end else if (cfg_wr_en_i) begin
      max_len_q <= cfg_wr_data_i;
    end
  end

  lcpc_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pkt_i     (pkt_i),
    .advance_i (advance),
    .item_o    (item)
  );

  lcpc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item),
    .max_len_i (max_len_q),
    .advance_o (advance),
    .vrd_o     (vrd_o)
  );

endmodule

// File: hw/rtl/lcpc_in_stage.sv
module lcpc_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  lcpc_byte_if.sink           pkt_i,
  input  logic                advance_i,
  output lcpc_pkg::lcpc_item_t item_o
);
  import lcpc_pkg::*;

  lcpc_item_t item_q;
  lcpc_item_t item_d;
  logic       take;

  // Accept when empty or when the held byte moves on this cycle
  assign pkt_i.ready = !item_q.vld || advance_i;
  assign take        = pkt_i.valid && pkt_i.ready;

  always_comb begin
    item_d = item_q;
    if (take) begin
      item_d.vld       = 1'b1;
      item_d.data_byte = pkt_i.data_byte;
      item_d.last_byte = pkt_i.last_byte;
    end else if (advance_i) begin
      item_d.vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

  // Held byte must stay while the core does not take it
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_q.vld && !advance_i |=> item_q.vld && $stable(item_q.data_byte)
                                 && $stable(item_q.last_byte))
    else $error("input stage dropped a held byte");

  // Core never advances an empty stage
  a_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i |-> item_q.vld)
    else $error("advance without a held byte");

  // A stalled stage refuses new bytes
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_q.vld && !advance_i |-> !pkt_i.ready)
    else $error("ready while stalled");

endmodule

// File: hw/rtl/lcpc_core.sv
module lcpc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcpc_pkg::lcpc_item_t          item_i,
  input  logic [lcpc_pkg::LenW-1:0]     max_len_i,
  output logic                          advance_o,
  lcpc_verdict_if.source                vrd_o
);
  import lcpc_pkg::*;

  // Packet state
  logic [CrcW-1:0]   crc_q, crc_d, crc_new;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_new;
  logic [LenW-1:0]   dlen_q, dlen_d, dlen_new;
  logic [ByteW-1:0]  held0_q, held0_d;
  logic [ByteW-1:0]  held1_q, held1_d;

  // Result register
  logic            out_vld_q, out_vld_d;
  logic            out_ok_q, out_ok_d;
  status_e         out_st_q, out_st_d;
  logic [CrcW-1:0] out_crc_q, out_crc_d;

  logic            fin;
  logic [ByteW-1:0] feed_byte;
  status_e         verdict;

  // Move on unless a final byte would overwrite an untaken verdict
  assign advance_o = item_i.vld && (!item_i.last_byte || !out_vld_q || vrd_o.ready);
  assign fin       = advance_o && item_i.last_byte;

  // Byte leaving the delay line enters the CRC, length bytes as zero
  always_comb begin
    feed_byte = (cnt_q == CountW'(2) || cnt_q == CountW'(3)) ? '0 : held0_q;
    crc_new   = (cnt_q >= CountW'(2)) ? crc_byte(crc_q, feed_byte) : crc_q;
    if (cnt_q == '0) begin
      dlen_new = {8'h00, item_i.data_byte};
    end else if (cnt_q == CountW'(1)) begin
      dlen_new = {item_i.data_byte, dlen_q[7:0]};
    end else begin
      dlen_new = dlen_q;
    end
    cnt_new = (cnt_q == CountMax) ? cnt_q : cnt_q + CountW'(1);
  end

  // Check in order: short, long, length, CRC
  always_comb begin
    if (cnt_new < MinLen) begin
      verdict = ST_TOO_SHORT;
    end else if (cnt_new > {1'b0, max_len_i}) begin
      verdict = ST_TOO_LONG;
    end else if ({1'b0, dlen_new} != cnt_new) begin
      verdict = ST_LEN_MISM;
    end else if ({item_i.data_byte, held1_q} != crc_new) begin
      verdict = ST_CRC_MISM;
    end else begin
      verdict = ST_VALID;
    end
  end

  // Update or clear the packet state
  always_comb begin
    crc_d   = crc_q;
    cnt_d   = cnt_q;
    dlen_d  = dlen_q;
    held0_d = held0_q;
    held1_d = held1_q;
    if (fin) begin
      crc_d   = CrcInit;
      cnt_d   = '0;
      dlen_d  = '0;
      held0_d = '0;
      held1_d = '0;
    end else if (advance_o) begin
      crc_d   = crc_new;
      cnt_d   = cnt_new;
      dlen_d  = dlen_new;
      held0_d = held1_q;
      held1_d = item_i.data_byte;
    end
  end

  // Load the verdict on a final byte, drop it once taken
  always_comb begin
    out_vld_d = out_vld_q;
    out_ok_d  = out_ok_q;
    out_st_d  = out_st_q;
    out_crc_d = out_crc_q;
    if (fin) begin
      out_vld_d = 1'b1;
      out_ok_d  = (verdict == ST_VALID);
      out_st_d  = verdict;
      out_crc_d = crc_new;
    end else if (vrd_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= CrcInit;
      cnt_q     <= '0;
      dlen_q    <= '0;
      held0_q   <= '0;
      held1_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      crc_q     <= crc_d;
      cnt_q     <= cnt_d;
      dlen_q    <= dlen_d;
      held0_q   <= held0_d;
      held1_q   <= held1_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ok_q  <= out_ok_d;
    out_st_q  <= out_st_d;
    out_crc_q <= out_crc_d;
  end

  assign vrd_o.valid        = out_vld_q;
  assign vrd_o.packet_ok    = out_ok_q;
  assign vrd_o.status       = out_st_q;
  assign vrd_o.computed_crc = out_crc_q;

  // Packet state starts over after each verdict
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> cnt_q == '0 && crc_q == CrcInit && dlen_q == '0)
    else $error("packet state not cleared after final byte");

  // Count grows by one per non-final byte until it saturates
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_o && !item_i.last_byte && cnt_q != CountMax |=> cnt_q == $past(cnt_q) + CountW'(1))
    else $error("byte count slipped");

  // An untaken verdict is never overwritten
  a_no_ovr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !vrd_o.ready |-> !fin)
    else $error("verdict overwritten");

  // A verdict appears only after a final byte
  a_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q ##1 out_vld_q |-> $past(fin))
    else $error("verdict without final byte");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import lcpc_pkg::*;

  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned CycleLimit = 3_000_000;

  typedef logic [ByteW-1:0] byte_q_t[$];

  typedef struct packed {
    logic            packet_ok;
    status_e         status;
    logic [CrcW-1:0] computed_crc;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [LenW-1:0] cfg_wr_data;

  lcpc_byte_if    pkt_if ();
  lcpc_verdict_if vrd_if ();

  length_crc_packet_checker i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .pkt_i         (pkt_if),
    .vrd_o         (vrd_if),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_wr_data_i (cfg_wr_data)
  );

  // Checker model state
  logic [CrcW-1:0]   model_crc;
  logic [CountW-1:0] model_count;
  logic [LenW-1:0]   model_decl;
  logic [ByteW-1:0]  model_hold [2];
  logic [LenW-1:0]   model_max_len;

  verdict_t pending_verdicts[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  bit sender_idle_off = 1'b0;
  bit rcv_idle_off = 1'b0;
  bit hold_req = 1'b0;

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // CRC-16/CCITT-FALSE, one bit at a time, MSB first
  function automatic logic [CrcW-1:0] crc16_ccitt_byte(input logic [CrcW-1:0] crc,
                                                       input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    logic fb;
    c = crc;
    for (int i = ByteW - 1; i >= 0; i--) begin
      fb = c[CrcW-1] ^ b[i];
      c = {c[CrcW-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
    end
    return c;
  endfunction

  function automatic void clear_packet_state();
    model_crc = CrcInit;
    model_count = '0;
    model_decl = '0;
    model_hold[0] = '0;
    model_hold[1] = '0;
  endfunction

  // Advance the model by one transferred byte; queue the verdict on a final byte
  function automatic void advance_checker_model(input logic [ByteW-1:0] b, input logic last);
    logic [CountW-1:0] len;
    logic [CrcW-1:0] given;
    verdict_t v;
    // the byte leaving the delay line enters the CRC; the length bytes enter as zero
    if (model_count >= 17'd2) begin
      model_crc = crc16_ccitt_byte(model_crc, (model_count < 17'd4) ? 8'h00 : model_hold[0]);
    end
    if (model_count == 17'd0) begin
      model_decl = {8'h00, b};
    end else if (model_count == 17'd1) begin
      model_decl[15:8] = b;
    end
    model_hold[0] = model_hold[1];
    model_hold[1] = b;
    if (model_count != CountMax) begin
      model_count = model_count + CountW'(1);
    end
    if (last) begin
      len = model_count;
      given = {model_hold[1], model_hold[0]};
      if (len < MinLen) begin
        v.status = ST_TOO_SHORT;
      end else if (len > {1'b0, model_max_len}) begin
        v.status = ST_TOO_LONG;
      end else if ({1'b0, model_decl} != len) begin
        v.status = ST_LEN_MISM;
      end else if (given != model_crc) begin
        v.status = ST_CRC_MISM;
      end else begin
        v.status = ST_VALID;
      end
      v.packet_ok = (v.status == ST_VALID);
      v.computed_crc = model_crc;
      pending_verdicts.push_back(v);
      clear_packet_state();
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Build a packet of len bytes; fill < 0 gives random content
  function automatic void make_packet(input int len, input logic [LenW-1:0] decl,
                                      input bit bad_crc, input int fill,
                                      output byte_q_t pkt);
    logic [CrcW-1:0] crc;
    logic [ByteW-1:0] b;
    pkt = {};
    if (len < 4) begin
      for (int i = 0; i < len; i++) begin
        b = (fill < 0) ? 8'($urandom) : 8'(fill);
        pkt.push_back(b);
      end
      return;
    end
    pkt.push_back(decl[7:0]);
    pkt.push_back(decl[15:8]);
    crc = crc16_ccitt_byte(crc16_ccitt_byte(CrcInit, 8'h00), 8'h00);
    for (int i = 2; i < len - 2; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      pkt.push_back(b);
      crc = crc16_ccitt_byte(crc, b);
    end
    if (bad_crc) begin
      crc ^= 16'(1) << $urandom_range(0, 15);
    end
    pkt.push_back(crc[7:0]);
    pkt.push_back(crc[15:8]);
  endfunction

  // Offer one byte, hold it until the transfer, then update the model
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int gap;
    gap = sender_idle_off ? 0 : idle_len();
    if (gap > 0) begin
      pkt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt_if.valid <= 1'b1;
    pkt_if.data_byte <= b;
    pkt_if.last_byte <= last;
    do @(posedge clk); while (!pkt_if.ready);
    advance_checker_model(b, last);
  endtask

  task automatic send_packet(input byte_q_t pkt);
    foreach (pkt[i]) begin
      send_byte(pkt[i], i == pkt.size() - 1);
    end
  endtask

  task automatic send_good(input int len);
    byte_q_t pkt;
    make_packet(len, 16'(len), 1'b0, -1, pkt);
    send_packet(pkt);
  endtask

  // Hold the sender until every verdict is in and the pipeline has drained
  task automatic wait_idle();
    pkt_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [LenW-1:0] value);
    wait_idle();
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    model_max_len = value;
    cfg_wr_en <= 1'b0;
  endtask

  // Short packets, boundary lengths, every verdict but too long, at the reset limit
  task automatic test_directed();
    byte_q_t pkt;
    make_packet(1, 16'd0, 1'b0, 8'hFF, pkt);
    send_packet(pkt);
    make_packet(2, 16'd0, 1'b0, 8'h00, pkt);
    send_packet(pkt);
    make_packet(3, 16'd0, 1'b0, -1, pkt);
    send_packet(pkt);
    make_packet(4, 16'd4, 1'b0, -1, pkt);
    send_packet(pkt);
    make_packet(6, 16'd6, 1'b0, 8'hFF, pkt);
    send_packet(pkt);
    make_packet(5, 16'd6, 1'b0, 8'h00, pkt);
    send_packet(pkt);
    make_packet(5, 16'd5, 1'b1, -1, pkt);
    send_packet(pkt);
  endtask

  task automatic test_config_extremes();
    byte_q_t pkt;
    write_max_length(16'd4);
    send_good(4);
    send_good(5);
    // limit below the minimum length
    write_max_length(16'd0);
    send_good(4);
    make_packet(3, 16'd0, 1'b0, -1, pkt);
    send_packet(pkt);
    write_max_length(16'd3);
    send_good(4);
    // largest limit
    write_max_length(16'hFFFF);
    send_good(30);
    write_max_length(MaxLenRst);
  endtask

  task automatic test_random();
    byte_q_t pkt;
    logic [LenW-1:0] limits [3];
    int sent;
    int kind;
    int len;
    int n;
    limits[0] = MaxLenRst;
    limits[1] = 16'($urandom_range(4, 30));
    limits[2] = 16'hFFFF;
    for (int ph = 0; ph < 3; ph++) begin
      write_max_length(limits[ph]);
      sent = 0;
      while (sent < 80) begin
        kind = $urandom_range(0, 99);
        len = $urandom_range(4, 24);
        if (kind < 70) begin
          make_packet(len, 16'(len), 1'b0, -1, pkt);
        end else if (kind < 78) begin
          make_packet(len, 16'(len), 1'b1, -1, pkt);
        end else if (kind < 86) begin
          make_packet(len, 16'(len) ^ (16'(1) << $urandom_range(0, 15)), 1'b0, -1, pkt);
        end else if (kind < 91) begin
          make_packet($urandom_range(1, 3), 16'd0, 1'b0, -1, pkt);
        end else if (kind < 95) begin
          if (model_max_len <= 16'd64) begin
            len = int'(model_max_len) + $urandom_range(1, 6);
          end
          make_packet(len, 16'(len), 1'b0, -1, pkt);
        end else begin
          // noise: random bytes and random final flags, always closed by a final byte
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++) begin
            send_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 5) == 0));
          end
          sent += n;
          continue;
        end
        send_packet(pkt);
        sent += pkt.size();
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering, then the sender drains
  task automatic test_backpressure();
    hold_req = 1'b1;
    sender_idle_off = 1'b1;
    repeat (12) send_good($urandom_range(4, 12));
    sender_idle_off = 1'b0;
    wait_idle();
    repeat (4) send_good($urandom_range(4, 10));
  endtask

  // Back-to-back packets with no idling on either side
  task automatic test_full_rate();
    sender_idle_off = 1'b1;
    rcv_idle_off = 1'b1;
    repeat (12) send_good($urandom_range(4, 8));
    sender_idle_off = 1'b0;
    rcv_idle_off = 1'b0;
  endtask

  // Verdict ready: random gaps, or one long hold-off on request
  initial begin : verdict_ready_gen
    int gap;
    vrd_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        vrd_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else begin
        gap = rcv_idle_off ? 0 : idle_len();
        if (gap == 0) begin
          vrd_if.ready <= 1'b1;
          @(posedge clk);
        end else begin
          vrd_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Compare each verdict transfer with the oldest pending verdict
  initial begin : verdict_check
    verdict_t exp_v;
    forever begin
      @(posedge clk);
      if (rst_n && vrd_if.valid && vrd_if.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected verdict: status %0d, computed_crc 0x%04h",
                 vrd_if.status, vrd_if.computed_crc);
          err_count++;
        end else begin
          exp_v = pending_verdicts.pop_front();
          if (vrd_if.packet_ok !== exp_v.packet_ok) begin
            $error("packet_ok: expected %0d, actual %0d", exp_v.packet_ok, vrd_if.packet_ok);
            err_count++;
          end
          if (vrd_if.status !== exp_v.status) begin
            $error("status: expected %0d, actual %0d", exp_v.status, vrd_if.status);
            err_count++;
          end
          if (vrd_if.computed_crc !== exp_v.computed_crc) begin
            $error("computed_crc: expected 0x%04h, actual 0x%04h",
                   exp_v.computed_crc, vrd_if.computed_crc);
            err_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : main_seq
    rst_n = 1'b0;
    pkt_if.valid = 1'b0;
    pkt_if.data_byte = '0;
    pkt_if.last_byte = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    model_max_len = MaxLenRst;
    clear_packet_state();
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_random();
    test_backpressure();
    test_full_rate();
    // drain and let any stray verdict show up
    pkt_if.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lcpc_pkg.sv
hw/rtl/lcpc_byte_if.sv
hw/rtl/lcpc_verdict_if.sv
hw/rtl/lcpc_in_stage.sv
hw/rtl/lcpc_core.sv
hw/rtl/length_crc_packet_checker.sv
tb/testbench.sv
